// ----- hdl/bmrz_pkg.sv -----
`default_nettype none

package bmrz_pkg;

  // Width of one bearing sample, hundredths of a degree, two's complement.
  localparam int BearingW = 17;

  // Width of a range sample in centimetres.
  localparam int RangeW = 16;

  // Width of the configuration data port, the widest register.
  localparam int CfgDataW = 16;

  // Width of the configuration register index.
  localparam int CfgIndexW = 3;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_WINDOW_LEN     = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_USE_MEDIAN     = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_PINGS_NEEDED   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_CLOSE_IN_BORDER = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_FAR_LIMIT      = 3'd4;

  // The only beacon type that is processed.
  localparam logic [7:0] KIND_ACCEPTED = 8'd0;

  // Hit counters stop here.
  localparam logic [7:0] HITS_MAX = 8'd255;

  // Zone codes on the result.
  localparam logic [1:0] ZONE_NONE     = 2'd0;
  localparam logic [1:0] ZONE_CLOSE_IN = 2'd1;
  localparam logic [1:0] ZONE_BUMP     = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_EMIT
  } state_t;

  // Controls broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic write;  // store the new bearing at the write position
    logic load;   // copy each entry into its circulating slot, clear the rank
    logic step;   // compare against the circulating slot, then shift the chain
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/bmrz_cell.sv -----
`default_nettype none

module bmrz_cell #(
  parameter int MAX_WINDOW = 16,
  parameter int IDX = 0,
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int LW = $clog2(MAX_WINDOW + 1)
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  bmrz_pkg::cell_ctl_t                   ctl,
  input  wire  [IW-1:0]                         wr_pos,
  input  wire  signed [bmrz_pkg::BearingW-1:0]  wr_val,
  input  wire  [LW-1:0]                         win_len,
  input  wire  signed [bmrz_pkg::BearingW-1:0]  pass_val_in,
  input  wire  [IW-1:0]                         pass_idx_in,
  output logic signed [bmrz_pkg::BearingW-1:0]  pass_val_out,
  output logic [IW-1:0]                         pass_idx_out,
  output logic signed [bmrz_pkg::BearingW-1:0]  entry_out,
  output logic                                  match
);

  logic signed [bmrz_pkg::BearingW-1:0] entry;
  logic signed [bmrz_pkg::BearingW-1:0] pass_val;
  logic [IW-1:0]                        pass_idx;
  logic [LW-1:0]                        rank;
  logic                                 active;
  logic                                 src_ok;
  logic                                 ranks_below;

  // The cell takes part only while it lies inside the window, and so does the sample passing by.
  assign active = LW'(IDX) < win_len;
  assign src_ok = LW'(pass_idx) < win_len;

  // A passing sample sorts below this entry if it is smaller, or equal and from a lower slot.
  assign ranks_below = (pass_val < entry) ||
                       ((pass_val == entry) && (pass_idx < IW'(IDX)));

  // The ring entry held by this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.write && (wr_pos == IW'(IDX))) begin
      entry <= wr_val;
    end
  end

  // Circulating slot and rank counter.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pass_val <= entry;
      pass_idx <= IW'(IDX);
      rank     <= '0;
    end else if (ctl.step) begin
      pass_val <= pass_val_in;
      pass_idx <= pass_idx_in;
      if (active && src_ok && ranks_below) begin
        rank <= rank + LW'(1);
      end
    end
  end

  assign pass_val_out = pass_val;
  assign pass_idx_out = pass_idx;
  assign entry_out    = entry;

  // The entry whose rank is half the window length is the upper median.
  assign match = active && (rank == (win_len >> 1));

endmodule

`default_nettype wire

// ----- hdl/bearing_median_and_range_zone_unit.sv -----
`default_nettype none

// Beacon bearing median filter and range zone tracker. Each report of beacon type 0 stores its
// bearing in a ring of window_len entries held by a chain of MAX_WINDOW cells, and gives one
// result beat: the upper median of the window (or the raw bearing when use_median is 0), the
// range, and the zone whose consecutive-hit count has reached pings_needed. Reports of any other
// type are taken and give nothing. With the median on, a report passes through these steps up to
// and including the load of the result register: the store, the load of the chain, a rotation in
// which every window sample travels once round the cell chain while each cell counts the
// samples that sort below its own, and the move of the result into the output register. With
// the median off it passes through the store and the move only. The next report is taken in the
// cycle after the move, so the unit takes no new report before it is through with the last one;
// a stalled result holds the sequencer in its last step until the output register is free.
// A new report is taken once the previous result is in the output register, even if that result
// is still stalled. Configuration must be written only while no report is in flight; the block
// itself does not enforce this.
module bearing_median_and_range_zone_unit #(
  parameter int MAX_WINDOW = 16
) (
  input  wire                                          clk,
  input  wire                                          rst,
  // Configuration write port.
  input  wire                                          cfg_write,
  input  wire  [bmrz_pkg::CfgIndexW-1:0]               cfg_index,
  input  wire  [bmrz_pkg::CfgDataW-1:0]                cfg_data,
  // Report channel.
  input  wire                                          in_valid,
  output logic                                         in_stall,
  input  wire  [7:0]                                   beacon_kind,
  input  wire  signed [bmrz_pkg::BearingW-1:0]         bearing,
  input  wire  [bmrz_pkg::RangeW-1:0]                  range_cm,
  // Result channel.
  output logic                                         out_valid,
  input  wire                                          out_stall,
  output logic signed [bmrz_pkg::BearingW-1:0]         filtered_bearing,
  output logic [bmrz_pkg::RangeW-1:0]                  range_out,
  output logic [1:0]                                   zone
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [4:0]                     cfg_window_len;
  logic                           cfg_use_median;
  logic [7:0]                     cfg_pings_needed;
  logic [bmrz_pkg::RangeW-1:0]    cfg_close_in_border;
  logic [bmrz_pkg::RangeW-1:0]    cfg_far_limit;

  // Sequencer and per-report state.
  bmrz_pkg::state_t               state;
  bmrz_pkg::state_t               state_next;
  bmrz_pkg::cell_ctl_t            ctl;
  logic [IW-1:0]                  wr_index;
  logic [IW-1:0]                  step_cnt;
  logic [7:0]                     close_hits;
  logic [7:0]                     bump_hits;
  logic [LW-1:0]                  item_len;
  logic                           item_median;
  logic signed [bmrz_pkg::BearingW-1:0] raw_bearing;
  logic [bmrz_pkg::RangeW-1:0]    item_range;
  logic [1:0]                     item_zone;
  logic                           out_load;

  // Combinational helpers.
  logic                           accept;
  logic                           take;
  logic [7:0]                     wl_ext;
  logic [7:0]                     len_ext;
  logic [LW-1:0]                  eff_len;
  logic [LW-1:0]                  wi_ext;
  logic [LW-1:0]                  pos;
  logic [LW-1:0]                  pos_inc;
  logic                           close_in;
  logic                           bump_in;
  logic [7:0]                     close_next;
  logic [7:0]                     bump_next;
  logic [1:0]                     zone_next;

  // Cell chain wiring.
  logic signed [bmrz_pkg::BearingW-1:0] pass_val [MAX_WINDOW];
  logic [IW-1:0]                  pass_idx [MAX_WINDOW];
  logic signed [bmrz_pkg::BearingW-1:0] entries [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]          match;
  logic signed [bmrz_pkg::BearingW-1:0] median;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_window_len      <= 5'd5;
      cfg_use_median      <= 1'b1;
      cfg_pings_needed    <= 8'd3;
      cfg_close_in_border <= 16'd500;
      cfg_far_limit       <= 16'd65535;
    end else if (cfg_write) begin
      case (cfg_index)
        bmrz_pkg::REG_WINDOW_LEN:      cfg_window_len      <= cfg_data[4:0];
        bmrz_pkg::REG_USE_MEDIAN:      cfg_use_median      <= cfg_data[0];
        bmrz_pkg::REG_PINGS_NEEDED:    cfg_pings_needed    <= cfg_data[7:0];
        bmrz_pkg::REG_CLOSE_IN_BORDER: cfg_close_in_border <= cfg_data;
        bmrz_pkg::REG_FAR_LIMIT:       cfg_far_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign take   = accept && (beacon_kind == bmrz_pkg::KIND_ACCEPTED);

  // Effective window length: zero counts as one, anything above the chain length is clamped.
  assign wl_ext = {3'b000, cfg_window_len};
  always_comb begin
    if (wl_ext == 8'd0) begin
      len_ext = 8'd1;
    end else if (wl_ext > 8'(MAX_WINDOW)) begin
      len_ext = 8'(MAX_WINDOW);
    end else begin
      len_ext = wl_ext;
    end
  end
  assign eff_len = LW'(len_ext);

  // Write position, folded back to the first entry when it lies past a shrunken window.
  assign wi_ext  = LW'(wr_index);
  assign pos     = (wi_ext < eff_len) ? wi_ext : '0;
  assign pos_inc = pos + LW'(1);

  // Zone membership and the saturating hit counts after this report.
  assign close_in   = (range_cm >= cfg_close_in_border) && (range_cm < cfg_far_limit);
  assign bump_in    = range_cm < cfg_close_in_border;
  assign close_next = !close_in ? 8'd0 :
                      (close_hits == bmrz_pkg::HITS_MAX) ? close_hits : close_hits + 8'd1;
  assign bump_next  = !bump_in ? 8'd0 :
                      (bump_hits == bmrz_pkg::HITS_MAX) ? bump_hits : bump_hits + 8'd1;

  // The bump zone is checked last, so it wins a tie.
  always_comb begin
    zone_next = bmrz_pkg::ZONE_NONE;
    if ((close_next >= cfg_pings_needed) && (close_next != 8'd0)) begin
      zone_next = bmrz_pkg::ZONE_CLOSE_IN;
    end
    if (bump_in && (bump_next >= cfg_pings_needed)) begin
      zone_next = bmrz_pkg::ZONE_BUMP;
    end
  end

  // Report state: ring position, hit counters and the fields held for the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index    <= '0;
      close_hits  <= 8'd0;
      bump_hits   <= 8'd0;
      item_len    <= LW'(1);
      item_median <= 1'b0;
    end else if (take) begin
      wr_index    <= (pos_inc >= eff_len) ? '0 : IW'(pos_inc);
      close_hits  <= close_next;
      bump_hits   <= bump_next;
      item_len    <= eff_len;
      item_median <= cfg_use_median;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      raw_bearing <= bearing;
      item_range  <= range_cm;
      item_zone   <= zone_next;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmrz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_next = state;
    ctl        = '0;
    out_load   = 1'b0;
    in_stall   = 1'b1;
    case (state)
      bmrz_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.write = take;
        if (take) begin
          state_next = cfg_use_median ? bmrz_pkg::ST_LOAD : bmrz_pkg::ST_EMIT;
        end
      end
      bmrz_pkg::ST_LOAD: begin
        ctl.load   = 1'b1;
        state_next = bmrz_pkg::ST_RANK;
      end
      bmrz_pkg::ST_RANK: begin
        ctl.step = 1'b1;
        if (step_cnt == IW'(MAX_WINDOW - 1)) begin
          state_next = bmrz_pkg::ST_EMIT;
        end
      end
      bmrz_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = bmrz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmrz_pkg::ST_IDLE;
      end
    endcase
  end

  // Rotation step counter.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      step_cnt <= '0;
    end else if (ctl.step) begin
      step_cnt <= step_cnt + IW'(1);
    end
  end

  // Chain of cells, closed into a ring so every sample visits every cell once.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    localparam int PREV = (k == 0) ? MAX_WINDOW - 1 : k - 1;
    bmrz_cell #(
      .MAX_WINDOW(MAX_WINDOW),
      .IDX       (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .wr_pos      (IW'(pos)),
      .wr_val      (bearing),
      .win_len     (item_len),
      .pass_val_in (pass_val[PREV]),
      .pass_idx_in (pass_idx[PREV]),
      .pass_val_out(pass_val[k]),
      .pass_idx_out(pass_idx[k]),
      .entry_out   (entries[k]),
      .match       (match[k])
    );
  end

  // Exactly one cell holds the median rank once the rotation is done.
  always_comb begin
    median = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      median = median | (match[k] ? entries[k] : '0);
    end
  end

  // Output register: loaded when it is empty or its beat is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_bearing <= item_median ? median : raw_bearing;
      range_out        <= item_range;
      zone             <= item_zone;
    end
  end

`ifndef SYNTHESIS
  // After a full rotation the ranks form a permutation, so the median cell is unique.
  assert property (@(posedge clk) disable iff (rst)
    (state == bmrz_pkg::ST_EMIT) && item_median |-> $onehot(match))
    else $error("median rank not unique");

  // The zones do not overlap, so at most one hit counter can be running.
  assert property (@(posedge clk) disable iff (rst)
    !((close_hits != 8'd0) && (bump_hits != 8'd0)))
    else $error("both hit counters running");

  // A new result beat only appears from the emit step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bmrz_pkg::ST_EMIT))
    else $error("result beat outside emit");
`endif

endmodule

`default_nettype wire
